/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the line byte FIFO checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is active.
`define LBF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Condition that must never be seen on a clock edge, off during reset.
`define LBF_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/lbf_pkg.sv */
// ---------------------------------------------------------------------------
// lbf_pkg
// Shared types, operation and status codes and default sizes of the line
// byte FIFO.
// ---------------------------------------------------------------------------
package lbf_pkg;

	localparam int BYTE_W = 8;

	// Default sizes
	localparam int DEF_QUEUE_DEPTH = 256;
	localparam int DEF_NUM_QUEUES  = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [1:0]        op_t;
	typedef logic [1:0]        stat_t;

	// Terminator after reset: newline
	localparam byte_t TERM_RESET = 8'd10;

	// Operation codes
	localparam op_t OP_PUSH  = 2'd0;
	localparam op_t OP_POP   = 2'd1;
	localparam op_t OP_CLEAR = 2'd2;

	// Result status codes
	localparam stat_t STAT_DONE     = 2'd0;
	localparam stat_t STAT_OVERFLOW = 2'd1;
	localparam stat_t STAT_DUP_TERM = 2'd2;
	localparam stat_t STAT_EMPTY    = 2'd3;

endpackage

/* rtl/line_byte_fifo_top.sv */
// ---------------------------------------------------------------------------
// line_byte_fifo_top
// Set of byte ring queues in one shared byte memory, each queue keeping a
// count of the complete lines (terminator bytes) it holds.
// ---------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------
//  in      | in_valid / in_ready      | operation, queue_index, data_byte
//  out     | out_valid / out_ready    | status, read_byte, fill_count,
//          |                          | lines_held
//  cfg     | cfg_we (no wait)         | cfg_data -> term_char
//
//  Push, clear and other words: result registered at the accept edge.
//  A pop reads the byte memory through its registered read port; in S_POP
//  the line count is fixed up from that byte and the result registered.
//  in_ready is low during the pop read and while an unread result is held.
//  Reset restores pointers, line counts, last byte and terminator at once;
//  the byte memory is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module line_byte_fifo_top #(
	parameter int QUEUE_DEPTH = lbf_pkg::DEF_QUEUE_DEPTH,
	parameter int NUM_QUEUES  = lbf_pkg::DEF_NUM_QUEUES
) (
	input  logic           clk,
	input  logic           arst_n,
	// configuration
	input  logic           cfg_we,
	input  lbf_pkg::byte_t cfg_data,
	// input words
	input  logic           in_valid,
	output logic           in_ready,
	input  lbf_pkg::op_t   operation,
	input  logic           queue_index,
	input  lbf_pkg::byte_t data_byte,
	// result words
	output logic           out_valid,
	input  logic           out_ready,
	output lbf_pkg::stat_t status,
	output lbf_pkg::byte_t read_byte,
	output lbf_pkg::byte_t fill_count,
	output lbf_pkg::byte_t lines_held
);
	import lbf_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic MULTI_Q = (NUM_QUEUES > 1);

	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_POP  = 1'b1;

	// Ring pointer increment with wrap at the queue depth
	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// Bytes held: (w - r - 1) mod depth
	function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] w,
			input logic [PW-1:0] r);
		logic [PW:0] tmp;
		if (w > r) begin
			tmp = {1'b0, w} - {1'b0, r} - 1'b1;
		end else begin
			tmp = {1'b0, w} + (PW+1)'(QUEUE_DEPTH) - {1'b0, r} - 1'b1;
		end
		return tmp[PW-1:0];
	endfunction

	// Byte memory address of slot p of queue q
	function automatic logic [AW-1:0] mem_addr(input logic [QW-1:0] q,
			input logic [PW-1:0] p);
		return AW'(q) * AW'(QUEUE_DEPTH) + AW'(p);
	endfunction

	// Control state
	logic            state_q;
	logic            out_valid_q;
	logic [PW-1:0]   wp_q [NUM_QUEUES];
	logic [PW-1:0]   rp_q [NUM_QUEUES];
	byte_t           lc_q [NUM_QUEUES];
	byte_t           prev_q;
	byte_t           term_q;

	// Byte memory and its registered read
	byte_t           mem [MEM_DEPTH];
	byte_t           rd_data_s1;
	logic [QW-1:0]   q_s1;
	logic [PW-1:0]   fill_s1;

	// Result register
	stat_t           status_q;
	byte_t           rbyte_q;
	byte_t           fill_q;
	byte_t           lines_q;

	logic            accept;
	logic            q_ok;
	logic [QW-1:0]   qi;
	logic [PW-1:0]   cur_w;
	logic [PW-1:0]   cur_r;
	byte_t           cur_lc;
	logic [PW-1:0]   w_next;
	logic [PW-1:0]   r_next;
	logic [PW-1:0]   fill_cur;
	logic            full;
	logic            empty;
	logic            is_term;
	logic            dup;
	byte_t           lc_inc;

	logic            do_push;
	logic            do_pop;
	logic            do_clear;
	stat_t           res_stat;
	logic [PW-1:0]   res_fill;
	byte_t           res_lines;

	byte_t           pop_lc;
	byte_t           pop_lc_new;
	logic            load_out;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);

	// Selected queue and its pointers
	assign qi      = QW'(queue_index);
	assign q_ok    = !queue_index || MULTI_Q;
	assign cur_w   = wp_q[qi];
	assign cur_r   = rp_q[qi];
	assign cur_lc  = lc_q[qi];
	assign w_next  = next_ptr(cur_w);
	assign r_next  = next_ptr(cur_r);
	assign fill_cur = fill_of(cur_w, cur_r);
	assign full    = (cur_w == cur_r);
	assign empty   = (r_next == cur_w);
	assign is_term = (data_byte == term_q);
	assign dup     = (prev_q == term_q) && is_term;
	assign lc_inc  = (is_term && cur_lc != '1) ? cur_lc + 1'b1 : cur_lc;

	// Decode of the accepted word
	always_comb begin
		do_push   = 1'b0;
		do_pop    = 1'b0;
		do_clear  = 1'b0;
		res_stat  = STAT_DONE;
		res_fill  = fill_cur;
		res_lines = cur_lc;
		if (!q_ok) begin
			res_fill  = '0;
			res_lines = '0;
		end else begin
			case (operation)
				OP_PUSH: begin
					if (full) begin
						do_clear  = 1'b1;
						res_stat  = STAT_OVERFLOW;
						res_fill  = '0;
						res_lines = '0;
					end else if (dup) begin
						res_stat = STAT_DUP_TERM;
					end else begin
						do_push   = 1'b1;
						res_fill  = fill_cur + 1'b1;
						res_lines = lc_inc;
					end
				end
				OP_POP: begin
					if (empty) begin
						res_stat = STAT_EMPTY;
					end else begin
						do_pop   = 1'b1;
						res_fill = fill_cur - 1'b1;
					end
				end
				OP_CLEAR: begin
					do_clear  = 1'b1;
					res_fill  = '0;
					res_lines = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Line count fix-up once the popped byte is back
	assign pop_lc     = lc_q[q_s1];
	assign pop_lc_new = (rd_data_s1 == term_q && pop_lc != '0) ? pop_lc - 1'b1 : pop_lc;

	assign load_out = (accept && !do_pop) || (state_q == S_POP);

	// Byte memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			mem[mem_addr(qi, cur_w)] <= data_byte;
		end
		rd_data_s1 <= mem[mem_addr(qi, r_next)];
	end

	// Queue control state, terminator and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			prev_q      <= '0;
			term_q      <= TERM_RESET;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				wp_q[i] <= '0;
				rp_q[i] <= PTR_LAST;
				lc_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				term_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_POP) begin
				lc_q[q_s1] <= pop_lc_new;
				state_q    <= S_IDLE;
			end else if (accept) begin
				if (do_clear) begin
					wp_q[qi] <= '0;
					rp_q[qi] <= PTR_LAST;
					lc_q[qi] <= '0;
				end
				if (do_push) begin
					wp_q[qi] <= w_next;
					lc_q[qi] <= lc_inc;
					prev_q   <= data_byte;
				end
				if (do_pop) begin
					rp_q[qi] <= r_next;
					state_q  <= S_POP;
				end
			end
		end
	end

	// Pop context and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			q_s1    <= qi;
			fill_s1 <= res_fill;
		end
		if (state_q == S_POP) begin
			status_q <= STAT_DONE;
			rbyte_q  <= rd_data_s1;
			fill_q   <= BYTE_W'(fill_s1);
			lines_q  <= pop_lc_new;
		end else if (accept && !do_pop) begin
			status_q <= res_stat;
			rbyte_q  <= '0;
			fill_q   <= BYTE_W'(res_fill);
			lines_q  <= res_lines;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_byte  = rbyte_q;
	assign fill_count = fill_q;
	assign lines_held = lines_q;

endmodule

/* rtl/lbf_checker.sv */
// ---------------------------------------------------------------------------
// lbf_checker
// Port-level checks on the result words of the line byte FIFO.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lbf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input lbf_pkg::stat_t status,
	input lbf_pkg::byte_t read_byte,
	input lbf_pkg::byte_t fill_count,
	input lbf_pkg::byte_t lines_held
);
	import lbf_pkg::*;

	// Only a successful pop carries a byte
	`LBF_NEVER(a_rbyte_only_done, clk, arst_n, out_valid && status != STAT_DONE && read_byte != '0, "read_byte set on a non-done result")

	// An empty pop reports an empty queue
	`LBF_ASSERT(a_empty_fill, clk, arst_n, out_valid && status == STAT_EMPTY |-> fill_count == '0, "empty status with nonzero fill")

	// Overflow leaves the queue cleared
	`LBF_ASSERT(a_ovf_cleared, clk, arst_n, out_valid && status == STAT_OVERFLOW |-> fill_count == '0 && lines_held == '0, "overflow did not clear queue")

	// A stalled result word holds its payload
	`LBF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_byte) && $stable(fill_count) && $stable(lines_held), "result changed while stalled")

endmodule

bind line_byte_fifo_top lbf_checker u_lbf_checker (.*);

/* test/line_byte_fifo_top_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// line_byte_fifo_top_tb
// Self-checking bench for the line byte FIFO. A short table of directed
// words comes first, with hand-read results where they are obvious. Random
// phases of line traffic then run under several terminator settings, plus
// one phase that fills both queues and drives the line count to its
// ceiling. All other result words are checked against a shadow copy of the
// queue state, and the sender and receiver both throttle at random.
// ---------------------------------------------------------------------------
module line_byte_fifo_top_tb;
	import lbf_pkg::*;

	// Code with no operation behind it: reports counts only
	localparam op_t OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PLAN_LEN = 24;

	typedef struct packed {
		stat_t stat;
		byte_t rbyte;
		byte_t fill;
		byte_t lines;
	} fifo_result_t;

	typedef struct packed {
		op_t          op;
		logic         q;
		byte_t        d;
		logic         typed;
		fifo_result_t want;
	} plan_row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_we = 1'b0;
	byte_t cfg_data = 8'h00;
	logic  in_valid = 1'b0;
	logic  in_ready;
	op_t   operation = OP_PUSH;
	logic  queue_index = 1'b0;
	byte_t data_byte = 8'h00;
	logic  out_valid;
	logic  out_ready = 1'b0;
	stat_t status;
	byte_t read_byte;
	byte_t fill_count;
	byte_t lines_held;

	// Shadow state; 8-bit pointers wrap at the 256-slot queue depth
	byte_t shadow_mem [2][256];
	byte_t shadow_wp [2];
	byte_t shadow_rp [2];
	byte_t shadow_lines [2];
	byte_t shadow_last;
	byte_t shadow_term;

	fifo_result_t due_results [$];

	int          errors = 0;
	int          words_sent = 0;
	int          results_seen = 0;
	int          term_writes = 0;
	int          burst_left = 0;
	int          stat_tally [4] = '{0, 0, 0, 0};
	int          peak_lines = 0;
	logic [31:0] cycles = 0;

	// Directed words: extremes, every code, shared last byte, empty pops
	plan_row_t plan [PLAN_LEN] = '{
		'{OP_POP,    1'b0, 8'h00, 1'b1, '{STAT_EMPTY,    8'h00, 8'd0, 8'd0}},
		'{OP_POP,    1'b1, 8'hFF, 1'b1, '{STAT_EMPTY,    8'h00, 8'd0, 8'd0}},
		'{OP_UNUSED, 1'b0, 8'hFF, 1'b1, '{STAT_DONE,     8'h00, 8'd0, 8'd0}},
		'{OP_PUSH,   1'b0, 8'h00, 1'b1, '{STAT_DONE,     8'h00, 8'd1, 8'd0}},
		'{OP_PUSH,   1'b0, 8'hFF, 1'b1, '{STAT_DONE,     8'h00, 8'd2, 8'd0}},
		'{OP_PUSH,   1'b0, 8'h0A, 1'b1, '{STAT_DONE,     8'h00, 8'd3, 8'd1}},
		'{OP_PUSH,   1'b0, 8'h0A, 1'b1, '{STAT_DUP_TERM, 8'h00, 8'd3, 8'd1}},
		// last byte is shared, so the other queue drops it too
		'{OP_PUSH,   1'b1, 8'h0A, 1'b1, '{STAT_DUP_TERM, 8'h00, 8'd0, 8'd0}},
		'{OP_PUSH,   1'b1, 8'h55, 1'b1, '{STAT_DONE,     8'h00, 8'd1, 8'd0}},
		'{OP_PUSH,   1'b1, 8'h0A, 1'b1, '{STAT_DONE,     8'h00, 8'd2, 8'd1}},
		'{OP_POP,    1'b0, 8'h00, 1'b1, '{STAT_DONE,     8'h00, 8'd2, 8'd1}},
		'{OP_POP,    1'b0, 8'h00, 1'b1, '{STAT_DONE,     8'hFF, 8'd1, 8'd1}},
		'{OP_POP,    1'b0, 8'h00, 1'b1, '{STAT_DONE,     8'h0A, 8'd0, 8'd0}},
		'{OP_POP,    1'b0, 8'h00, 1'b1, '{STAT_EMPTY,    8'h00, 8'd0, 8'd0}},
		'{OP_CLEAR,  1'b1, 8'hAA, 1'b1, '{STAT_DONE,     8'h00, 8'd0, 8'd0}},
		'{OP_POP,    1'b1, 8'h00, 1'b1, '{STAT_EMPTY,    8'h00, 8'd0, 8'd0}},
		'{OP_PUSH,   1'b0, 8'h0A, 1'b1, '{STAT_DUP_TERM, 8'h00, 8'd0, 8'd0}},
		'{OP_PUSH,   1'b1, 8'hAA, 1'b1, '{STAT_DONE,     8'h00, 8'd1, 8'd0}},
		'{OP_UNUSED, 1'b1, 8'h00, 1'b1, '{STAT_DONE,     8'h00, 8'd1, 8'd0}},
		'{OP_PUSH,   1'b0, 8'h0A, 1'b1, '{STAT_DONE,     8'h00, 8'd1, 8'd1}},
		'{OP_PUSH,   1'b1, 8'h7F, 1'b0, '{STAT_DONE,     8'h00, 8'd0, 8'd0}},
		'{OP_POP,    1'b1, 8'h80, 1'b0, '{STAT_DONE,     8'h00, 8'd0, 8'd0}},
		'{OP_CLEAR,  1'b0, 8'h00, 1'b1, '{STAT_DONE,     8'h00, 8'd0, 8'd0}},
		'{OP_POP,    1'b1, 8'h00, 1'b0, '{STAT_DONE,     8'h00, 8'd0, 8'd0}}
	};

	line_byte_fifo_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.queue_index (queue_index),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.read_byte   (read_byte),
		.fill_count  (fill_count),
		.lines_held  (lines_held)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Queue back to its reset pointers, no lines held
	function automatic void shadow_clear(input logic q);
		shadow_wp[q] = 8'h00;
		shadow_rp[q] = 8'hFF;
		shadow_lines[q] = 8'h00;
	endfunction

	// Apply one word to the shadow state and return the result it gives
	function automatic fifo_result_t predict_queue_op(input op_t op, input logic q,
			input byte_t d);
		fifo_result_t r;
		byte_t nxt;
		r = '{STAT_DONE, 8'h00, 8'h00, 8'h00};
		case (op)
			OP_PUSH: begin
				if (shadow_wp[q] == shadow_rp[q]) begin
					shadow_clear(q);
					r.stat = STAT_OVERFLOW;
				end else if (shadow_last == shadow_term && d == shadow_term) begin
					r.stat = STAT_DUP_TERM;
				end else begin
					shadow_mem[q][shadow_wp[q]] = d;
					shadow_wp[q] = shadow_wp[q] + 8'd1;
					if (d == shadow_term && shadow_lines[q] != 8'hFF)
						shadow_lines[q] = shadow_lines[q] + 8'd1;
					shadow_last = d;
				end
			end
			OP_POP: begin
				nxt = shadow_rp[q] + 8'd1;
				if (nxt == shadow_wp[q]) begin
					r.stat = STAT_EMPTY;
				end else begin
					shadow_rp[q] = nxt;
					r.rbyte = shadow_mem[q][nxt];
					if (r.rbyte == shadow_term && shadow_lines[q] != 8'h00)
						shadow_lines[q] = shadow_lines[q] - 8'd1;
				end
			end
			OP_CLEAR: shadow_clear(q);
			default: ;
		endcase
		r.fill = shadow_wp[q] - shadow_rp[q] - 8'd1;
		r.lines = shadow_lines[q];
		return r;
	endfunction

	// Random byte, extremes favored, that is neither a nor b
	function automatic byte_t other_byte(input byte_t a, input byte_t b);
		byte_t v;
		case ($urandom_range(0, 7))
			0: v = 8'h00;
			1: v = 8'hFF;
			default: v = 8'($urandom);
		endcase
		while (v == a || v == b)
			v = v + 8'd1;
		return v;
	endfunction

	// Hold the word until accepted, then keep the burst or open a gap
	task automatic drive_word(input op_t op, input logic q, input byte_t d);
		in_valid    <= 1'b1;
		operation   <= op;
		queue_index <= q;
		data_byte   <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic send_word(input op_t op, input logic q, input byte_t d);
		due_results.push_back(predict_queue_op(op, q, d));
		drive_word(op, q, d);
	endtask

	// Stop sending until every result is back, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_term(input byte_t t);
		cfg_we   <= 1'b1;
		cfg_data <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_term = t;
		term_writes++;
	endtask

	// Mostly whole lines and pop runs, with clears and stray words mixed in
	task automatic random_phase(input int budget);
		int stop_at;
		int pick;
		logic q;
		stop_at = words_sent + budget;
		while (words_sent < stop_at) begin
			q = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 19);
			if (pick < 9) begin
				repeat ($urandom_range(0, 10))
					send_word(OP_PUSH, q, other_byte(shadow_term, shadow_term));
				send_word(OP_PUSH, q, shadow_term);
			end else if (pick < 16) begin
				repeat ($urandom_range(1, 12))
					send_word(OP_POP, q, 8'($urandom));
			end else if (pick < 17) begin
				send_word(OP_CLEAR, q, 8'($urandom));
			end else begin
				send_word(op_t'($urandom_range(0, 3)), q,
					($urandom_range(0, 2) == 0) ? shadow_term : 8'($urandom));
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Receiver: stall pattern cycles through four modes; result check; watchdog
	always @(posedge clk) begin
		fifo_result_t want;
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("line_byte_fifo_top_tb: errors");
			$finish;
		end else begin
			if (arst_n && out_valid && out_ready) begin
				results_seen++;
				stat_tally[status]++;
				if (int'(lines_held) > peak_lines)
					peak_lines = int'(lines_held);
				if (due_results.size() == 0) begin
					$error("result word arrived with none expected");
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("status", int'(want.stat), int'(status));
					check_field("read_byte", int'(want.rbyte), int'(read_byte));
					check_field("fill_count", int'(want.fill), int'(fill_count));
					check_field("lines_held", int'(want.lines), int'(lines_held));
				end
			end
			case (cycles[9:8])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= ($urandom_range(0, 3) != 0);
				2'd2: out_ready <= (cycles[2:0] != 3'd5);
				default: out_ready <= (cycles[4:0] < 5'd20);
			endcase
		end
	end

	initial begin
		int i;
		byte_t sat_a;
		byte_t sat_b;
		fifo_result_t pred;
		byte_t term_plan [5];

		shadow_clear(1'b0);
		shadow_clear(1'b1);
		shadow_last = 8'h00;
		shadow_term = TERM_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; the shadow state advances on every row
		for (i = 0; i < PLAN_LEN; i++) begin
			pred = predict_queue_op(plan[i].op, plan[i].q, plan[i].d);
			due_results.push_back(plan[i].typed ? plan[i].want : pred);
			drive_word(plan[i].op, plan[i].q, plan[i].d);
		end

		// Extremes first; bytes left from one setting become terminators of the next
		term_plan = '{8'h0A, 8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
		for (i = 0; i < 3; i++) begin
			wait_drained();
			write_term(term_plan[i]);
			random_phase(180);
		end

		// Line count ceiling: filler into queue 1 lets queue 0 take back-to-back
		// terminators; a second setting then stacks new lines on the old count
		sat_a = 8'($urandom);
		sat_b = sat_a ^ 8'h3C;
		wait_drained();
		write_term(sat_a);
		send_word(OP_CLEAR, 1'b0, 8'h00);
		send_word(OP_CLEAR, 1'b1, 8'h00);
		repeat (254) begin
			send_word(OP_PUSH, 1'b1, other_byte(sat_a, sat_b));
			send_word(OP_PUSH, 1'b0, sat_a);
		end
		wait_drained();
		write_term(sat_b);
		send_word(OP_POP, 1'b0, 8'h00);
		send_word(OP_PUSH, 1'b0, sat_b);
		send_word(OP_PUSH, 1'b1, other_byte(sat_a, sat_b));
		send_word(OP_PUSH, 1'b0, sat_b);
		// both queues now full: each push clears its queue
		send_word(OP_PUSH, 1'b0, other_byte(sat_a, sat_b));
		send_word(OP_PUSH, 1'b1, other_byte(sat_a, sat_b));

		for (i = 3; i < 5; i++) begin
			wait_drained();
			write_term(term_plan[i]);
			random_phase(180);
		end

		wait_drained();
		$display("%0d words over %0d terminator writes, %0d results checked",
			words_sent, term_writes, results_seen);
		$display("done %0d, overflow %0d, duplicate %0d, empty %0d, peak lines %0d",
			stat_tally[STAT_DONE], stat_tally[STAT_OVERFLOW], stat_tally[STAT_DUP_TERM],
			stat_tally[STAT_EMPTY], peak_lines);
		if (errors == 0)
			$display("line_byte_fifo_top_tb: clean");
		else
			$display("line_byte_fifo_top_tb: errors");
		$finish;
	end

endmodule

/* line_byte_fifo_top.f */
+incdir+rtl
rtl/lbf_pkg.sv
rtl/line_byte_fifo_top.sv
rtl/lbf_checker.sv
test/line_byte_fifo_top_tb.sv
